// File: design/ols_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ols_pkg;

  localparam int unsigned Depth   = 16;
  localparam int unsigned IdxW    = $clog2(Depth);
  localparam int unsigned CntW    = $clog2(Depth + 1);
  localparam int unsigned DataW   = 32;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PosW    = 4;
  localparam int unsigned OccW    = 5;

  typedef enum logic [ModeW-1:0] {
    MODE_INS_FRONT = 3'd0,
    MODE_INS_BACK  = 3'd1,
    MODE_REM_FRONT = 3'd2,
    MODE_REM_VALUE = 3'd3,
    MODE_SEARCH    = 3'd4
  } mode_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CMP   = 5'b00010,
    S_SCAN  = 5'b00100,
    S_APPLY = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_LOAD      = 2'd1,
    CELL_FROM_PREV = 2'd2,
    CELL_FROM_NEXT = 2'd3
  } cell_cmd_e;

  typedef struct packed {
    cell_cmd_e cmd;
    logic      cmp_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: design/ols_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ols_cell (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire ols_pkg::cell_ctl_t               ctl_i,
  input  wire logic signed [ols_pkg::DataW-1:0] key_i,
  input  wire logic signed [ols_pkg::DataW-1:0] prev_data_i,
  input  wire logic signed [ols_pkg::DataW-1:0] next_data_i,
  output logic signed [ols_pkg::DataW-1:0]      data_o,
  output logic                                  hit_o
);

  logic signed [ols_pkg::DataW-1:0] data_q, data_d;
  logic                             hit_q, hit_d;

  always_comb begin
    case (ctl_i.cmd)
      ols_pkg::CELL_LOAD:      data_d = key_i;
      ols_pkg::CELL_FROM_PREV: data_d = prev_data_i;
      ols_pkg::CELL_FROM_NEXT: data_d = next_data_i;
      default:                 data_d = data_q;
    endcase
    hit_d = ctl_i.cmp_en ? (data_q == key_i) : hit_q;
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  assign data_o = data_q;
  assign hit_o  = hit_q;

endmodule

`default_nettype wire

// File: design/ordered_list_store.sv
// Bounded ordered list of 16 signed 32-bit words, usable as stack, queue or
// list, built as a row of cells that shift toward or away from the front.
// One word at a time: insert front, insert back and remove front go from
// acceptance straight to the apply step; search and remove by value first
// compare all cells in parallel, then a scan steps one cell per cycle until
// the first match or the end of the held words before the apply step. A new
// word is taken in the cycle after the result word is taken. Inserts into a
// full list are refused with status full; a remove front on an empty list
// reports empty.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_store (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [ols_pkg::ModeW-1:0]          mode_i,
  input  wire logic signed [ols_pkg::DataW-1:0]   value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [ols_pkg::StatusW-1:0]             status_o,
  output logic signed [ols_pkg::DataW-1:0]        removed_value_o,
  output logic [ols_pkg::PosW-1:0]                position_o,
  output logic [ols_pkg::OccW-1:0]                occupancy_o
);

  ols_pkg::state_e                  state_q, state_d;
  ols_pkg::mode_e                   mode_q, mode_d;
  logic signed [ols_pkg::DataW-1:0] key_q, key_d;
  logic [ols_pkg::CntW-1:0]         idx_q, idx_d;
  logic                             found_q, found_d;
  logic [ols_pkg::CntW-1:0]         count_q, count_d;
  ols_pkg::status_e                 status_q, status_d;
  logic signed [ols_pkg::DataW-1:0] removed_q, removed_d;
  logic [ols_pkg::PosW-1:0]         pos_q, pos_d;

  ols_pkg::cell_ctl_t               ctl [ols_pkg::Depth];
  logic signed [ols_pkg::DataW-1:0] cell_data [ols_pkg::Depth];
  logic [ols_pkg::Depth-1:0]        hit;

  logic full, empty;

  assign full  = (count_q == ols_pkg::CntW'(ols_pkg::Depth));
  assign empty = (count_q == '0);

  for (genvar g = 0; g < ols_pkg::Depth; g++) begin : g_cell
    logic signed [ols_pkg::DataW-1:0] prev_data, next_data;
    if (g == 0) begin : g_first
      assign prev_data = key_q;
    end else begin : g_mid
      assign prev_data = cell_data[g-1];
    end
    if (g == ols_pkg::Depth - 1) begin : g_last
      assign next_data = key_q;
    end else begin : g_inner
      assign next_data = cell_data[g+1];
    end
    ols_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl[g]),
      .key_i       (key_q),
      .prev_data_i (prev_data),
      .next_data_i (next_data),
      .data_o      (cell_data[g]),
      .hit_o       (hit[g])
    );
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    key_d     = key_q;
    idx_d     = idx_q;
    found_d   = found_q;
    count_d   = count_q;
    status_d  = status_q;
    removed_d = removed_q;
    pos_d     = pos_q;
    for (int i = 0; i < ols_pkg::Depth; i++) begin
      ctl[i].cmd    = ols_pkg::CELL_HOLD;
      ctl[i].cmp_en = 1'b0;
    end

    case (state_q)
      ols_pkg::S_IDLE: begin
        if (in_valid_i) begin
          mode_d = ols_pkg::mode_e'(mode_i);
          key_d  = value_i;
          if (mode_i == ols_pkg::MODE_REM_VALUE || mode_i == ols_pkg::MODE_SEARCH) begin
            state_d = ols_pkg::S_CMP;
          end else begin
            state_d = ols_pkg::S_APPLY;
          end
        end
      end
      ols_pkg::S_CMP: begin
        for (int i = 0; i < ols_pkg::Depth; i++) begin
          ctl[i].cmp_en = 1'b1;
        end
        idx_d   = '0;
        found_d = 1'b0;
        state_d = ols_pkg::S_SCAN;
      end
      ols_pkg::S_SCAN: begin
        if (idx_q == count_q) begin
          state_d = ols_pkg::S_APPLY;
        end else if (hit[idx_q[ols_pkg::IdxW-1:0]]) begin
          found_d = 1'b1;
          state_d = ols_pkg::S_APPLY;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ols_pkg::S_APPLY: begin
        status_d  = ols_pkg::ST_OK;
        removed_d = '0;
        pos_d     = '0;
        case (mode_q)
          ols_pkg::MODE_INS_FRONT: begin
            if (full) begin
              status_d = ols_pkg::ST_FULL;
            end else begin
              for (int i = 0; i < ols_pkg::Depth; i++) begin
                ctl[i].cmd = (i == 0) ? ols_pkg::CELL_LOAD : ols_pkg::CELL_FROM_PREV;
              end
              count_d = count_q + 1'b1;
            end
          end
          ols_pkg::MODE_INS_BACK: begin
            if (full) begin
              status_d = ols_pkg::ST_FULL;
            end else begin
              for (int i = 0; i < ols_pkg::Depth; i++) begin
                if (ols_pkg::CntW'(i) == count_q) begin
                  ctl[i].cmd = ols_pkg::CELL_LOAD;
                end
              end
              count_d = count_q + 1'b1;
            end
          end
          ols_pkg::MODE_REM_FRONT: begin
            if (empty) begin
              status_d = ols_pkg::ST_EMPTY;
            end else begin
              removed_d = cell_data[0];
              for (int i = 0; i < ols_pkg::Depth; i++) begin
                ctl[i].cmd = ols_pkg::CELL_FROM_NEXT;
              end
              count_d = count_q - 1'b1;
            end
          end
          ols_pkg::MODE_REM_VALUE: begin
            if (!found_q) begin
              status_d = ols_pkg::ST_NOTFOUND;
            end else begin
              for (int i = 0; i < ols_pkg::Depth; i++) begin
                if (ols_pkg::CntW'(i) >= idx_q) begin
                  ctl[i].cmd = ols_pkg::CELL_FROM_NEXT;
                end
              end
              count_d = count_q - 1'b1;
            end
          end
          ols_pkg::MODE_SEARCH: begin
            if (!found_q) begin
              status_d = ols_pkg::ST_NOTFOUND;
            end else begin
              pos_d = ols_pkg::PosW'(idx_q);
            end
          end
          default: begin
          end
        endcase
        state_d = ols_pkg::S_RESP;
      end
      ols_pkg::S_RESP: begin
        if (out_ready_i) begin
          state_d = ols_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = ols_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ols_pkg::S_IDLE;
      count_q <= '0;
      found_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      found_q <= found_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q    <= mode_d;
    key_q     <= key_d;
    status_q  <= status_d;
    removed_q <= removed_d;
    pos_q     <= pos_d;
  end

  assign in_ready_o      = (state_q == ols_pkg::S_IDLE);
  assign out_valid_o     = (state_q == ols_pkg::S_RESP);
  assign status_o        = status_q;
  assign removed_value_o = removed_q;
  assign position_o      = pos_q;
  assign occupancy_o     = ols_pkg::OccW'(count_q);

endmodule

`default_nettype wire

// File: design/ols_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ols_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_ready_o,
  input wire logic                             out_valid_o,
  input wire logic                             out_ready_i,
  input wire logic [ols_pkg::StatusW-1:0]      status_o,
  input wire logic signed [ols_pkg::DataW-1:0] removed_value_o,
  input wire logic [ols_pkg::PosW-1:0]         position_o,
  input wire logic [ols_pkg::OccW-1:0]         occupancy_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(removed_value_o) && $stable(position_o) && $stable(occupancy_o))
    else $error("result word changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> occupancy_o <= ols_pkg::OccW'(ols_pkg::Depth))
    else $error("occupancy beyond depth");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ols_pkg::ST_FULL
      |-> occupancy_o == ols_pkg::OccW'(ols_pkg::Depth))
    else $error("full status with room left");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ols_pkg::ST_EMPTY |-> occupancy_o == '0
      && removed_value_o == '0)
    else $error("empty status with entries held");

endmodule

bind ordered_list_store ols_checker u_ols_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .removed_value_o (removed_value_o),
  .position_o      (position_o),
  .occupancy_o     (occupancy_o)
);

`default_nettype wire

// File: tb/ordered_list_store_checker.sv
`timescale 1ns / 1ps

module ordered_list_store_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_ready_i,
  input  logic [ols_pkg::ModeW-1:0]             mode_i,
  input  logic signed [ols_pkg::DataW-1:0]      value_i,
  input  logic                                  out_valid_i,
  input  logic                                  out_ready_i,
  input  logic [ols_pkg::StatusW-1:0]           status_i,
  input  logic signed [ols_pkg::DataW-1:0]      removed_value_i,
  input  logic [ols_pkg::PosW-1:0]              position_i,
  input  logic [ols_pkg::OccW-1:0]              occupancy_i,
  output int unsigned                           mismatches_o,
  output int unsigned                           pending_o,
  output int unsigned                           results_o,
  output int unsigned                           full_refusals_o,
  output int unsigned                           empty_pops_o
);

  import ols_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [DataW-1:0]   removed;
    logic [PosW-1:0]    pos;
    logic [OccW-1:0]    occ;
  } list_result_t;

  logic [DataW-1:0] cells [Depth];
  int               held;
  list_result_t     expected_results [$];
  list_result_t     want;

  task automatic report_mismatch(input string msg);
    mismatches_o++;
    if (mismatches_o <= 40) $display("mismatch: %s", msg);
  endtask

  task automatic close_gap(input int at);
    int k;
    for (k = at; k + 1 < held; k++) cells[k] = cells[k + 1];
    held--;
  endtask

  task automatic apply_word(input logic [ModeW-1:0] op, input logic [DataW-1:0] data);
    list_result_t r;
    int           hit;
    int           k;
    r.status  = ST_OK;
    r.removed = '0;
    r.pos     = '0;
    hit       = -1;
    for (k = 0; k < held; k++) begin
      if (hit < 0 && cells[k] == data) hit = k;
    end
    case (op)
      MODE_INS_FRONT: begin
        if (held >= Depth) begin
          r.status = ST_FULL;
          full_refusals_o++;
        end else begin
          for (k = held; k > 0; k--) cells[k] = cells[k - 1];
          cells[0] = data;
          held++;
        end
      end
      MODE_INS_BACK: begin
        if (held >= Depth) begin
          r.status = ST_FULL;
          full_refusals_o++;
        end else begin
          cells[held] = data;
          held++;
        end
      end
      MODE_REM_FRONT: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
          empty_pops_o++;
        end else begin
          r.removed = cells[0];
          close_gap(0);
        end
      end
      MODE_REM_VALUE: begin
        if (hit < 0) r.status = ST_NOTFOUND;
        else close_gap(hit);
      end
      MODE_SEARCH: begin
        if (hit < 0) r.status = ST_NOTFOUND;
        else r.pos = hit[PosW-1:0];
      end
      default: begin
      end
    endcase
    r.occ = held[OccW-1:0];
    expected_results.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held = 0;
      expected_results.delete();
      mismatches_o    = 0;
      pending_o       = 0;
      results_o       = 0;
      full_refusals_o = 0;
      empty_pops_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_o++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word %0d arrived with nothing expected", results_o));
        end else begin
          want = expected_results.pop_front();
          if (status_i !== want.status)
            report_mismatch($sformatf("word %0d status %0d, want %0d",
                                      results_o, status_i, want.status));
          if (removed_value_i !== want.removed)
            report_mismatch($sformatf("word %0d removed_value %h, want %h",
                                      results_o, removed_value_i, want.removed));
          if (position_i !== want.pos)
            report_mismatch($sformatf("word %0d position %0d, want %0d",
                                      results_o, position_i, want.pos));
          if (occupancy_i !== want.occ)
            report_mismatch($sformatf("word %0d occupancy %0d, want %0d",
                                      results_o, occupancy_i, want.occ));
        end
      end
      if (in_valid_i && in_ready_i) apply_word(mode_i, value_i);
      pending_o = expected_results.size();
    end
  end

endmodule

// File: tb/ordered_list_store_tb.sv
`timescale 1ns / 1ps

module ordered_list_store_tb;

  import ols_pkg::*;

  localparam logic [ModeW-1:0] MODE_NOP_LO = 3'd5;
  localparam logic [ModeW-1:0] MODE_NOP_HI = 3'd7;
  localparam int               IdleLimit   = 5000;
  localparam int               NumPhases   = 8;
  localparam int               PhaseWords  = 240;
  localparam int               HoldOffAt   = 400;
  localparam int               HoldOffLen  = 300;

  logic                     clk_i;
  logic                     rst_n     = 1'b0;
  logic                     in_valid  = 1'b0;
  logic [ModeW-1:0]         mode      = '0;
  logic signed [DataW-1:0]  value     = '0;
  logic                     out_ready = 1'b0;

  logic                     in_ready;
  logic                     out_valid;
  logic [StatusW-1:0]       status;
  logic signed [DataW-1:0]  removed_value;
  logic [PosW-1:0]          position;
  logic [OccW-1:0]          occupancy;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned result_count;
  int unsigned full_count;
  int unsigned empty_count;

  int               idle_cycles = 0;
  int               burst_left  = 0;
  bit               no_gaps     = 1'b0;
  int               words_sent  = 0;
  logic [DataW-1:0] pool [8];

  ordered_list_store dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .mode_i          (mode),
    .value_i         (value),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .removed_value_o (removed_value),
    .position_o      (position),
    .occupancy_o     (occupancy)
  );

  ordered_list_store_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .mode_i          (mode),
    .value_i         (value),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .status_i        (status),
    .removed_value_i (removed_value),
    .position_i      (position),
    .occupancy_i     (occupancy),
    .mismatches_o    (mismatch_count),
    .pending_o       (pending_count),
    .results_o       (result_count),
    .full_refusals_o (full_count),
    .empty_pops_o    (empty_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[ordered_list_store] ERROR");
      $finish;
    end
  end

  task automatic offer_word(input logic [ModeW-1:0] op, input logic [DataW-1:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    mode     <= op;
    value    <= data;
    do @(posedge clk_i); while (!in_ready);
    words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (pending_count != 0);
    @(posedge clk_i);
  endtask

  function automatic logic [DataW-1:0] pick_value();
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [ModeW-1:0] pick_mode(input int ins_pct);
    int roll;
    int split;
    roll = $urandom_range(0, 99);
    if (roll < 3) return ModeW'($urandom_range(MODE_NOP_LO, MODE_NOP_HI));
    if (roll < 3 + ins_pct) return $urandom_range(0, 1) ? MODE_INS_FRONT : MODE_INS_BACK;
    split = $urandom_range(0, 9);
    if (split < 4) return MODE_REM_FRONT;
    if (split < 7) return MODE_REM_VALUE;
    return MODE_SEARCH;
  endfunction

  initial begin : receiver
    int ready_pct;
    int pattern_left;
    int taken;
    bit held_off;
    ready_pct    = 100;
    pattern_left = 0;
    taken        = 0;
    held_off     = 1'b0;
    do @(posedge clk_i); while (!rst_n);
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) taken++;
      if (!held_off && taken >= HoldOffAt) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HoldOffLen) @(posedge clk_i);
      end else begin
        if (pattern_left == 0) begin
          pattern_left = $urandom_range(20, 200);
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 70;
            2: ready_pct = 40;
            default: ready_pct = 15;
          endcase
        end
        pattern_left--;
        out_ready <= ($urandom_range(1, 100) <= ready_pct);
      end
    end
  end

  initial begin : stimulus
    int k;
    int phase;
    int ins_pct;
    logic [ModeW-1:0] op;
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    offer_word(MODE_REM_FRONT, 32'd0);
    offer_word(MODE_SEARCH, 32'd0);
    offer_word(MODE_REM_VALUE, 32'd0);
    offer_word(MODE_INS_FRONT, 32'h8000_0000);
    offer_word(MODE_INS_BACK, 32'h7fff_ffff);
    offer_word(MODE_NOP_LO, 32'hffff_ffff);
    offer_word(MODE_NOP_HI, 32'h0000_0000);
    for (k = 0; k < 14; k++)
      offer_word((k % 2 == 0) ? MODE_INS_FRONT : MODE_INS_BACK, 32'h100 + k);
    offer_word(MODE_INS_BACK, 32'hdead_beef);
    offer_word(MODE_INS_FRONT, 32'hdead_beef);
    offer_word(MODE_SEARCH, 32'h10d);
    offer_word(MODE_REM_VALUE, 32'h105);
    wait_drained();

    for (phase = 0; phase < NumPhases; phase++) begin
      for (k = 0; k < 8; k++) pool[k] = $urandom;
      ins_pct = (phase % 2 == 0) ? $urandom_range(55, 80) : $urandom_range(15, 40);
      no_gaps = (phase == 3) || (phase == 6);
      for (k = 0; k < PhaseWords; k++) begin
        op = pick_mode(ins_pct);
        offer_word(op, pick_value());
      end
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    $display("summary: %0d words over %0d random phases, %0d results checked",
             words_sent, NumPhases, result_count);
    $display("summary: %0d inserts refused when full, %0d pops of an empty list",
             full_count, empty_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("[ordered_list_store] OK");
    end else begin
      $display("[ordered_list_store] ERROR");
    end
    $finish;
  end

endmodule
